[sv/pppdf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pppdf_pkg
// Shared types and constants of the PPP async deframer.
// ----------------------------------------------------------------------------
package pppdf_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 16;

  localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
  localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;
  localparam logic [LEN_W-1:0]  FCS_LEN   = 16'd2;

  localparam logic [LEN_W-1:0] MAX_FRAME_LEN_RST = 16'd4096;
  localparam int               QUEUE_DEPTH_DEF   = 4;

  // result kind, carried on out_tuser
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_END     = 2'd1,
    KIND_ESCFLAG = 2'd2,
    KIND_OVERRUN = 2'd3
  } kind_t;

  // one decoded command from front to back
  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data_byte;  // payload byte (also the byte sent before END)
    logic [LEN_W-1:0]  frame_len;  // frame length for END
    logic              pre_data;   // send data_byte as a payload word before END
  } cmd_t;

endpackage
`default_nettype wire

[sv/pppdf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pppdf_front
// Byte classifier: unescapes, tracks frame count and two-byte hold, and
// pushes one command per byte that produces any result.
// ----------------------------------------------------------------------------
module pppdf_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [pppdf_pkg::LEN_W-1:0]   cfg_wr_data,
  input  wire logic                          byte_vld,
  input  wire logic [pppdf_pkg::BYTE_W-1:0]  byte_in,
  output pppdf_pkg::cmd_t                    cmd,
  output logic                               cmd_push
);

  logic                         esc_r, esc_nxt;
  logic [pppdf_pkg::LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [pppdf_pkg::LEN_W-1:0]  max_len_r;
  logic [pppdf_pkg::BYTE_W-1:0] hold0_r, hold0_nxt, hold1_r, hold1_nxt;
  logic                         is_flag, is_esc;
  logic [pppdf_pkg::BYTE_W-1:0] ubyte;

  assign is_flag = (byte_in == pppdf_pkg::FLAG_BYTE);
  assign is_esc  = (byte_in == pppdf_pkg::ESC_BYTE);
  assign ubyte   = esc_r ? (byte_in ^ pppdf_pkg::ESC_XOR) : byte_in;

  // classify the byte and update frame state
  always_comb begin
    esc_nxt        = esc_r;
    cnt_nxt        = cnt_r;
    hold0_nxt      = hold0_r;
    hold1_nxt      = hold1_r;
    cmd_push       = 1'b0;
    cmd.kind       = pppdf_pkg::KIND_DATA;
    cmd.data_byte  = hold0_r;
    cmd.frame_len  = '0;
    cmd.pre_data   = 1'b0;
    if (byte_vld) begin
      priority if (is_flag) begin
        if (esc_r) begin
          cmd_push = 1'b1;
          cmd.kind = pppdf_pkg::KIND_ESCFLAG;
          esc_nxt  = 1'b0;
          cnt_nxt  = '0;
        end else if (cnt_r != '0) begin
          cmd_push = 1'b1;
          cmd.kind = pppdf_pkg::KIND_END;
          cnt_nxt  = '0;
          if (cnt_r == pppdf_pkg::LEN_W'(1)) begin
            // single-byte frame goes out whole
            cmd.pre_data  = 1'b1;
            cmd.frame_len = pppdf_pkg::LEN_W'(1);
          end else begin
            cmd.frame_len = cnt_r - pppdf_pkg::FCS_LEN;
          end
        end
      end else if (is_esc) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        if (cnt_r >= max_len_r) begin
          cmd_push = 1'b1;
          cmd.kind = pppdf_pkg::KIND_OVERRUN;
          cnt_nxt  = '0;
        end else if (cnt_r == '0) begin
          hold0_nxt = ubyte;
          cnt_nxt   = pppdf_pkg::LEN_W'(1);
        end else if (cnt_r == pppdf_pkg::LEN_W'(1)) begin
          hold1_nxt = ubyte;
          cnt_nxt   = pppdf_pkg::LEN_W'(2);
        end else begin
          // older held byte leaves, new byte enters the hold
          cmd_push  = 1'b1;
          hold0_nxt = hold1_r;
          hold1_nxt = ubyte;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
    end
  end

  // control state and config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r     <= 1'b0;
      cnt_r     <= '0;
      max_len_r <= pppdf_pkg::MAX_FRAME_LEN_RST;
    end else begin
      esc_r <= esc_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

  // hold bytes, no reset
  always_ff @(posedge clk) begin
    hold0_r <= hold0_nxt;
    hold1_r <= hold1_nxt;
  end

  a_flag_clears_esc: assert property (@(posedge clk) disable iff (!rst_n)
    byte_vld && is_flag |=> !esc_r)
    else $error("escape still pending after flag");

  a_frame_end_clears_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push && (cmd.kind != pppdf_pkg::KIND_DATA) |=> cnt_r == '0)
    else $error("frame count not cleared after frame end or error");

  a_data_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push && cmd.kind == pppdf_pkg::KIND_DATA |-> cnt_r >= pppdf_pkg::LEN_W'(2))
    else $error("payload word sent with fewer than two held bytes");

endmodule
`default_nettype wire

[sv/pppdf_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pppdf_queue
// Small command queue between classifier and result sequencer.
// ----------------------------------------------------------------------------
module pppdf_queue #(
  parameter int DEPTH = pppdf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire pppdf_pkg::cmd_t wr_cmd,
  input  wire logic      pop,
  output pppdf_pkg::cmd_t rd_cmd,
  output logic           not_empty,
  output logic           full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pppdf_pkg::cmd_t   slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_cmd    = slot_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("command pushed into full queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue fill count out of range");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not advance on push");

endmodule
`default_nettype wire

[sv/pppdf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pppdf_back
// Result sequencer: expands commands into result words and holds them in
// the output register.
// ----------------------------------------------------------------------------
module pppdf_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pppdf_pkg::cmd_t               head,
  input  wire logic                          head_vld,
  output logic                               pop,
  output logic                               out_vld,
  input  wire logic                          out_rdy,
  output pppdf_pkg::kind_t                   out_kind,
  output logic [pppdf_pkg::BYTE_W-1:0]       out_data,
  output logic [pppdf_pkg::LEN_W-1:0]        out_len,
  output logic                               out_last
);

  typedef enum logic [1:0] {
    PH_FIRST = 2'b01,
    PH_FINAL = 2'b10
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic                         vld_r, vld_nxt;
  pppdf_pkg::kind_t             kind_r, kind_nxt;
  logic [pppdf_pkg::BYTE_W-1:0] data_r, data_nxt;
  logic [pppdf_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic                         last_r, last_nxt;
  logic                         load;

  assign load = head_vld && (!vld_r || out_rdy);

  // pick the next result word
  always_comb begin
    phase_nxt = phase_r;
    vld_nxt   = vld_r && !out_rdy;
    kind_nxt  = kind_r;
    data_nxt  = data_r;
    len_nxt   = len_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (load) begin
      vld_nxt = 1'b1;
      if (head.pre_data && phase_r == PH_FIRST) begin
        // leading payload byte of a single-byte frame
        kind_nxt  = pppdf_pkg::KIND_DATA;
        data_nxt  = head.data_byte;
        len_nxt   = '0;
        last_nxt  = 1'b0;
        phase_nxt = PH_FINAL;
      end else begin
        kind_nxt  = head.kind;
        data_nxt  = (head.kind == pppdf_pkg::KIND_DATA) ? head.data_byte : '0;
        len_nxt   = (head.kind == pppdf_pkg::KIND_END) ? head.frame_len : '0;
        last_nxt  = 1'b1;
        phase_nxt = PH_FIRST;
        pop       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      vld_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      vld_r   <= vld_nxt;
    end
  end

  // output payload, no reset
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    data_r <= data_nxt;
    len_r  <= len_nxt;
    last_r <= last_nxt;
  end

  assign out_vld  = vld_r;
  assign out_kind = kind_r;
  assign out_data = data_r;
  assign out_len  = len_r;
  assign out_last = last_r;

  a_final_keeps_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FINAL |-> head_vld && head.pre_data)
    else $error("second word pending without its command");

  a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FINAL |-> vld_r && !last_r)
    else $error("leading payload word marked last");

endmodule
`default_nettype wire

[sv/ppp_async_frame_deframer_top.sv]
// Latency: a result word passes through the command queue and then the output register before it is valid.
// Throughput: 1 byte per cycle; results leave at 1 word per cycle from the
//   output register while out_tready holds; a one-byte frame end gives two words.
// Bytes stall only when the command queue (QUEUE_DEPTH entries) is full.
// Reset (rst_n low, synchronous) clears escape state, frame count, queue and
//   output valid, and sets max_frame_len to 4096.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppp_async_frame_deframer_top
// PPP asynchronous framing deframer: unescapes bytes, strips FCS, reports
// frame ends and errors as a result stream.
// ----------------------------------------------------------------------------
module ppp_async_frame_deframer_top #(
  parameter int QUEUE_DEPTH = pppdf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,   // max_frame_len
  // byte input
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // [7:0] byte_in
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,     // [7:0] data_byte, [23:8] frame_len
  output logic [1:0]       out_tuser,     // [1:0] kind
  output logic             out_tlast      // last
);

  pppdf_pkg::cmd_t              push_cmd, head_cmd;
  logic                         push, pop, head_vld, q_full, in_acc;
  pppdf_pkg::kind_t             res_kind;
  logic [pppdf_pkg::BYTE_W-1:0] res_data;
  logic [pppdf_pkg::LEN_W-1:0]  res_len;

  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  pppdf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_vld    (in_acc),
    .byte_in     (in_tdata),
    .cmd         (push_cmd),
    .cmd_push    (push)
  );

  pppdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_cmd    (push_cmd),
    .pop       (pop),
    .rd_cmd    (head_cmd),
    .not_empty (head_vld),
    .full      (q_full)
  );

  pppdf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head_cmd),
    .head_vld (head_vld),
    .pop      (pop),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .out_kind (res_kind),
    .out_data (res_data),
    .out_len  (res_len),
    .out_last (out_tlast)
  );

  assign out_tdata = {res_len, res_data};
  assign out_tuser = res_kind;

endmodule
`default_nettype wire

[tb/ppp_async_frame_deframer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_async_frame_deframer_top_tb
// Drives a stuffed PPP byte stream into the deframer: a few hand-picked
// frames first, then random frames with random content, mixed with line
// noise, escaped flags and double escapes, over several max_frame_len
// settings. A scoreboard works out the expected result words per accepted
// byte and checks every word that leaves the block, field by field.
// ----------------------------------------------------------------------------
module ppp_async_frame_deframer_top_tb;

  localparam int CLK_HALF       = 5;
  localparam int RST_CYCLES     = 7;
  localparam int SETTLE_CYCLES  = 12;   // pipeline plus command queue, with margin
  localparam int RX_HOLD_CYCLES = 150;
  localparam int PHASE_BYTES    = 330;
  localparam int NUM_PHASES     = 6;

  // one result word as the block presents it
  typedef struct {
    pppdf_pkg::kind_t kind;
    logic [7:0]       data_byte;
    logic [15:0]      frame_len;
    logic             last;
  } deframe_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: deframer state mirror plus the queue of words still owed
  // --------------------------------------------------------------------------
  class deframe_checker;
    logic [15:0]   max_len;
    bit            esc_pend;
    logic [15:0]   fcount;
    logic [7:0]    hold [2];
    deframe_word_t owed_words [$];
    int            errors;

    function new();
      max_len  = pppdf_pkg::MAX_FRAME_LEN_RST;
      esc_pend = 1'b0;
      fcount   = '0;
      hold[0]  = '0;
      hold[1]  = '0;
      errors   = 0;
    endfunction

    function void owe(pppdf_pkg::kind_t k, logic [7:0] d, logic [15:0] n, logic l);
      deframe_word_t w;
      w.kind      = k;
      w.data_byte = d;
      w.frame_len = n;
      w.last      = l;
      owed_words.push_back(w);
    endfunction

    // deframe one raw byte accepted by the block
    function void accept_byte(logic [7:0] raw);
      logic [7:0] b;
      b = raw;
      if (b == pppdf_pkg::FLAG_BYTE) begin
        if (esc_pend) begin
          esc_pend = 1'b0;
          fcount   = '0;
          owe(pppdf_pkg::KIND_ESCFLAG, 8'h00, 16'd0, 1'b1);
        end else if (fcount == 16'd1) begin
          // single-byte frame comes out whole
          owe(pppdf_pkg::KIND_DATA, hold[0], 16'd0, 1'b0);
          owe(pppdf_pkg::KIND_END, 8'h00, 16'd1, 1'b1);
          fcount = '0;
        end else if (fcount >= 16'd2) begin
          // held bytes are the FCS, dropped
          owe(pppdf_pkg::KIND_END, 8'h00, fcount - pppdf_pkg::FCS_LEN, 1'b1);
          fcount = '0;
        end
      end else if (b == pppdf_pkg::ESC_BYTE) begin
        esc_pend = 1'b1;
      end else begin
        if (esc_pend) b = b ^ pppdf_pkg::ESC_XOR;
        esc_pend = 1'b0;
        if (fcount >= max_len) begin
          fcount = '0;
          owe(pppdf_pkg::KIND_OVERRUN, 8'h00, 16'd0, 1'b1);
        end else if (fcount == 16'd0) begin
          hold[0] = b;
          fcount  = 16'd1;
        end else if (fcount == 16'd1) begin
          hold[1] = b;
          fcount  = 16'd2;
        end else begin
          owe(pppdf_pkg::KIND_DATA, hold[0], 16'd0, 1'b1);
          hold[0] = hold[1];
          hold[1] = b;
          fcount  = fcount + 16'd1;
        end
      end
    endfunction

    function void check_word(pppdf_pkg::kind_t k, logic [7:0] d, logic [15:0] n,
                             logic l);
      deframe_word_t w;
      if (owed_words.size() == 0) begin
        $display("%0t: unexpected word kind=%0d data=%02h len=%0d last=%0b",
                 $time, k, d, n, l);
        errors++;
      end else begin
        w = owed_words.pop_front();
        if (k !== w.kind || d !== w.data_byte || n !== w.frame_len || l !== w.last) begin
          $display("%0t: mismatch expected kind=%0d data=%02h len=%0d last=%0b",
                   $time, w.kind, w.data_byte, w.frame_len, w.last);
          $display("%0t:          actual   kind=%0d data=%02h len=%0d last=%0b",
                   $time, k, d, n, l);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  deframe_checker chk = new();
  logic [7:0]     raw_q [$];
  bit             tx_gaps_on;
  bit             rx_hold_req;

  ppp_async_frame_deframer_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  // clock
  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // watchdog
  initial begin
    #8000000;
    $display("ppp_async_frame_deframer_top_tb: FAIL");
    $finish;
  end

  // handshake monitor
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) chk.accept_byte(in_tdata);
    if (rst_n && out_tvalid && out_tready)
      chk.check_word(pppdf_pkg::kind_t'(out_tuser), out_tdata[7:0], out_tdata[23:8],
                     out_tlast);
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // result sink: random ready pattern, plus one long hold-off on request
  initial begin
    int rx_run;
    bit rx_on;
    rx_run     = 0;
    rx_on      = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_on       = 1'b0;
        rx_run      = RX_HOLD_CYCLES;
      end else if (rx_run == 0) begin
        rx_on  = !rx_on;
        rx_run = rx_on ? int'($urandom_range(1, 40)) : pick_gap();
        if (rx_run == 0) begin
          rx_on  = 1'b1;
          rx_run = int'($urandom_range(1, 40));
        end
      end
      out_tready <= rx_on;
      rx_run--;
    end
  end

  // --------------------------------------------------------------------------
  // Stream building
  // --------------------------------------------------------------------------
  // stuff one payload byte; flag and escape always, other bytes sometimes escaped
  function automatic void add_payload(logic [7:0] b);
    bit esc;
    esc = (b == pppdf_pkg::FLAG_BYTE) || (b == pppdf_pkg::ESC_BYTE) ||
          ((b ^ pppdf_pkg::ESC_XOR) != pppdf_pkg::FLAG_BYTE &&
           (b ^ pppdf_pkg::ESC_XOR) != pppdf_pkg::ESC_BYTE &&
           $urandom_range(0, 9) == 0);
    if (esc) begin
      raw_q.push_back(pppdf_pkg::ESC_BYTE);
      raw_q.push_back(b ^ pppdf_pkg::ESC_XOR);
    end else begin
      raw_q.push_back(b);
    end
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] picks [7];
    picks = '{8'h7E, 8'h7D, 8'h5E, 8'h5D, 8'h00, 8'hFF, 8'h20};
    if ($urandom_range(0, 7) == 0) return picks[$urandom_range(0, 6)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_frame_len(int max_len);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return int'($urandom_range(0, 2));
    if (r < 80) return int'($urandom_range(3, 14));
    if (r < 95 && max_len <= 300) return max_len - 1 + int'($urandom_range(0, 3));
    return int'($urandom_range(15, 40));
  endfunction

  // one random sequence: mostly well-formed frames, the rest noise and breakage
  function automatic void add_sequence(int max_len);
    int unsigned r;
    int          n;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      if ($urandom_range(0, 2) == 0) raw_q.push_back(pppdf_pkg::FLAG_BYTE);
      n = pick_frame_len(max_len);
      repeat (n) add_payload(pick_byte());
      raw_q.push_back(pppdf_pkg::FLAG_BYTE);
    end else if (r < 88) begin
      repeat ($urandom_range(1, 6)) raw_q.push_back(8'($urandom_range(0, 255)));
    end else if (r < 94) begin
      raw_q.push_back(pppdf_pkg::ESC_BYTE);
      raw_q.push_back(pppdf_pkg::FLAG_BYTE);
    end else begin
      raw_q.push_back(pppdf_pkg::ESC_BYTE);
      raw_q.push_back(pppdf_pkg::ESC_BYTE);
      raw_q.push_back(pick_byte());
    end
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, int gap);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (chk.owed_words.size() != 0) @(negedge clk);
  endtask

  // no words owed and the pipeline settled
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // send the whole byte queue; pause_at >= 0 stops there until all words arrive
  task automatic send_stream(bit no_gaps, int pause_at);
    int i;
    for (i = 0; i < raw_q.size(); i++) begin
      if (i % 64 == 0) tx_gaps_on = !no_gaps && ($urandom_range(0, 3) != 0);
      if (i == pause_at) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        wait_drained();
      end
      send_byte(raw_q[i], tx_gaps_on ? pick_gap() : 0);
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
    raw_q.delete();
  endtask

  task automatic write_max_len(logic [15:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    chk.max_len = v;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [15:0] max_vals [NUM_PHASES];
    int          p;

    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    tx_gaps_on  = 1'b0;
    rx_hold_req = 1'b0;
    max_vals = '{16'd1, 16'd2, 16'd65535, 16'($urandom_range(3, 40)),
                 16'($urandom_range(4, 200)), 16'd4096};

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed frames at the reset frame limit
    raw_q = '{8'h7E,                                  // flag on empty frame
              8'h00, 8'h7E,                           // single-byte frame
              8'h11, 8'hFF, 8'h7E,                    // FCS only, length 0
              8'h01, 8'h02, 8'h03, 8'h04, 8'h7E,      // two payload bytes
              8'h7D, 8'h5E, 8'h7D, 8'h5D,             // escaped flag and escape
              8'h7D, 8'h7D, 8'h33,                    // escape after escape
              8'hAA, 8'hBB, 8'h7E,
              8'h7D, 8'h7E};                          // escaped flag error
    send_stream(1'b0, -1);

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_max_len(max_vals[p]);
      // frame full at the smallest limit, escape pending into an overrun
      if (p == 0) raw_q = '{8'h41, 8'h42, 8'h7E, 8'h43, 8'h7E, 8'h41, 8'h7D, 8'h62};
      while (raw_q.size() < PHASE_BYTES) add_sequence(int'(max_vals[p]));
      // back-pressure phase: sink holds off while bytes keep coming
      if (p == 2) rx_hold_req = 1'b1;
      send_stream(p == 2, (p == 3) ? PHASE_BYTES / 2 : -1);
    end

    wait_idle();
    if (chk.errors == 0) begin
      $display("ppp_async_frame_deframer_top_tb: PASS");
    end else begin
      $display("ppp_async_frame_deframer_top_tb: FAIL");
    end
    $finish;
  end

endmodule
